// ===== design/stum_pkg.sv =====
`timescale 1ns / 1ps
package stum_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DW = 32;
    localparam int QW = DW + FRAC_BITS;
    localparam int DIV_STEPS = QW;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FOVX   = 2'd2;
    localparam logic [1:0] REG_FOVY   = 2'd3;

    typedef logic signed [DW-1:0] t_fix;

    function automatic t_fix sat(input logic signed [79:0] x);
        if (x > 80'sd2147483647) return 32'sh7fffffff;
        if (x < -80'sd2147483648) return 32'sh80000000;
        return x[DW-1:0];
    endfunction

    function automatic t_fix fadd(input t_fix a, input t_fix b);
        return sat(80'(a) + 80'(b));
    endfunction

    function automatic t_fix fsub(input t_fix a, input t_fix b);
        return sat(80'(a) - 80'(b));
    endfunction

    // Arithmetic shift of the exact product rounds toward minus infinity.
    function automatic t_fix fmul(input t_fix a, input t_fix b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat(80'(p >>> FRAC_BITS));
    endfunction
endpackage

// ===== design/stum_div.sv =====
`timescale 1ns / 1ps
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Numerator is up to 80 bits wide; the quotient is built in QW bits and saturates to DW bits.
module stum_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic signed [79:0] i_num,
    input  logic signed [63:0] i_den,
    output stum_pkg::t_fix o_q
);
    localparam int N = stum_pkg::DIV_STEPS;
    logic [79:0] r_rem [0:N];
    logic [63:0] r_dv  [0:N];
    logic [N-1:0] r_q  [0:N];
    logic         r_neg[0:N];
    logic         r_big[0:N];
    logic [79:0] n_mag;
    logic [63:0] n_dmag;

    always_comb begin
        n_mag  = i_num[79] ? 80'(-i_num) : i_num;
        n_dmag = i_den[63] ? 64'(-i_den) : i_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_mag;
            r_dv[0]  <= n_dmag;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[79] ^ i_den[63];
            // Quotient is certainly at least 2^N when the high numerator bits are at least the divisor.
            r_big[0] <= (n_mag >> N) >= 80'(n_dmag);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [127:0] n_sh;
        assign n_sh = {64'd0, r_dv[k]} << (N - 1 - k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k+1]  <= r_dv[k];
                r_neg[k+1] <= r_neg[k];
                r_big[k+1] <= r_big[k];
                if (128'(r_rem[k]) >= n_sh) begin
                    r_rem[k+1] <= r_rem[k] - n_sh[79:0];
                    r_q[k+1]   <= r_q[k] | (N'(1) << (N - 1 - k));
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
            end
        end
    end

    logic signed [79:0] n_sq;
    always_comb begin
        n_sq = r_neg[N] ? -80'(r_q[N]) : 80'(r_q[N]);
        if (r_big[N]) n_sq = r_neg[N] ? -80'sd4294967296 : 80'sd4294967296;
        o_q = stum_pkg::sat(n_sq);
    end
endmodule

// ===== design/screen_to_texture_uvz_mapper.sv =====
`timescale 1ns / 1ps
// Pipeline, in order from the accepting edge to a valid result: one input stage,
// a DIV_STEPS+1 (49) stage projection divide, two stages of products and sums,
// a 49 stage final divide and the output register.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// The divider chains, one quotient bit per stage, set the depth.
// Reset (synchronous, active low) clears valid bits and restores default registers.
module screen_to_texture_uvz_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_screen_x, i_screen_y,
    input  logic signed [31:0] i_origin_x, i_origin_y, i_origin_z,
    input  logic signed [31:0] i_u_tip_x, i_u_tip_y, i_u_tip_z,
    input  logic signed [31:0] i_v_tip_x, i_v_tip_y, i_v_tip_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_tex_u, o_tex_v, o_depth_z,
    output logic        o_degenerate
);
    localparam int F = stum_pkg::FRAC_BITS;
    localparam int ND = stum_pkg::DIV_STEPS + 1;
    localparam int LAT = 4 + 2 * ND;

    logic [12:0] r_w, r_h;
    logic [30:0] r_fx, r_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 13'd640; r_h <= 13'd480;
            r_fx <= 31'(1 << F); r_fy <= 31'(1 << F);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stum_pkg::REG_WIDTH:  r_w  <= i_cfg_data[12:0];
                stum_pkg::REG_HEIGHT: r_h  <= i_cfg_data[12:0];
                stum_pkg::REG_FOVX:   r_fx <= i_cfg_data;
                stum_pkg::REG_FOVY:   r_fy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic [LAT-1:0] r_v;
    assign en = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[LAT-2:0], i_valid};
    end

    // Stage 1: differences, projection numerators and denominators.
    stum_pkg::t_fix r_s1_ox, r_s1_oy, r_s1_oz, r_s1_ux, r_s1_uy, r_s1_uz;
    stum_pkg::t_fix r_s1_vx, r_s1_vy, r_s1_vz;
    logic signed [79:0] r_s1_nx, r_s1_ny;
    logic signed [63:0] r_s1_hd, r_s1_vd;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ox <= i_origin_x; r_s1_oy <= i_origin_y; r_s1_oz <= i_origin_z;
            r_s1_ux <= stum_pkg::fsub(i_u_tip_x, i_origin_x);
            r_s1_uy <= stum_pkg::fsub(i_u_tip_y, i_origin_y);
            r_s1_uz <= stum_pkg::fsub(i_u_tip_z, i_origin_z);
            r_s1_vx <= stum_pkg::fsub(i_v_tip_x, i_origin_x);
            r_s1_vy <= stum_pkg::fsub(i_v_tip_y, i_origin_y);
            r_s1_vz <= stum_pkg::fsub(i_v_tip_z, i_origin_z);
            r_s1_nx <= (80'(i_screen_x) - (80'(r_w >> 1) <<< F)) <<< F;
            r_s1_ny <= ((80'(r_h >> 1) <<< F) - 80'(i_screen_y)) <<< F;
            r_s1_hd <= 64'(r_w) * 64'(r_fx);
            r_s1_vd <= 64'(r_h) * 64'(r_fy);
        end
    end

    // Projection divides run in parallel with the cross products.
    stum_pkg::t_fix n_px, n_py;
    stum_div u_dpx (.i_clk, .i_en(en), .i_num(r_s1_nx),
        .i_den(r_s1_hd == 0 ? 64'sd1 : r_s1_hd), .o_q(n_px));
    stum_div u_dpy (.i_clk, .i_en(en), .i_num(r_s1_ny),
        .i_den(r_s1_vd == 0 ? 64'sd1 : r_s1_vd), .o_q(n_py));

    // Stage 2: cross terms, then delayed to meet px/py.
    stum_pkg::t_fix r_s2_c1, r_s2_c2, r_s2_c3, r_s2_a, r_s2_b, r_s2_e, r_s2_f;
    stum_pkg::t_fix r_s2_k, r_s2_l;
    logic r_s2_hz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_c1 <= stum_pkg::fsub(stum_pkg::fmul(r_s1_uz, r_s1_vy),
                                      stum_pkg::fmul(r_s1_uy, r_s1_vz));
            r_s2_c2 <= stum_pkg::fsub(stum_pkg::fmul(r_s1_ux, r_s1_vz),
                                      stum_pkg::fmul(r_s1_uz, r_s1_vx));
            r_s2_c3 <= stum_pkg::fsub(stum_pkg::fmul(r_s1_uy, r_s1_vx),
                                      stum_pkg::fmul(r_s1_ux, r_s1_vy));
            r_s2_a  <= stum_pkg::fsub(stum_pkg::fmul(r_s1_oy, r_s1_vz),
                                      stum_pkg::fmul(r_s1_oz, r_s1_vy));
            r_s2_b  <= stum_pkg::fsub(stum_pkg::fmul(r_s1_oz, r_s1_vx),
                                      stum_pkg::fmul(r_s1_ox, r_s1_vz));
            r_s2_e  <= stum_pkg::fsub(stum_pkg::fmul(r_s1_oy, r_s1_uz),
                                      stum_pkg::fmul(r_s1_oz, r_s1_uy));
            r_s2_f  <= stum_pkg::fsub(stum_pkg::fmul(r_s1_oz, r_s1_ux),
                                      stum_pkg::fmul(r_s1_ox, r_s1_uz));
            r_s2_k  <= stum_pkg::fmul(r_s1_oy, r_s1_vx);
            r_s2_l  <= stum_pkg::fmul(r_s1_oy, r_s1_ux);
            r_s2_hz <= (r_s1_hd == 0) || (r_s1_vd == 0);
        end
    end
    stum_pkg::t_fix r_s2_m, r_s2_n, r_s2_oz;
    stum_pkg::t_fix r_s2_ox, r_s2_oy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_m <= stum_pkg::fmul(r_s1_ox, r_s1_vy);
            r_s2_n <= stum_pkg::fmul(r_s1_ox, r_s1_uy);
            r_s2_ox <= r_s1_ox; r_s2_oy <= r_s1_oy; r_s2_oz <= r_s1_oz;
        end
    end

    localparam int NW = 13;
    logic [NW*32-1:0] r_dl [0:ND-2];
    logic             r_dz [0:ND-2];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0] <= {r_s2_c1, r_s2_c2, r_s2_c3, r_s2_a, r_s2_b, r_s2_e, r_s2_f,
                        r_s2_k, r_s2_l, r_s2_m, r_s2_n, r_s2_ox, r_s2_oy};
            r_dz[0] <= r_s2_hz;
            for (int i = 1; i < ND - 1; i++) begin
                r_dl[i] <= r_dl[i-1];
                r_dz[i] <= r_dz[i-1];
            end
        end
    end
    // Keep oz alongside separately.
    stum_pkg::t_fix r_ozd [0:ND-2];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ozd[0] <= r_s2_oz;
            for (int i = 1; i < ND - 1; i++) r_ozd[i] <= r_ozd[i-1];
        end
    end

    stum_pkg::t_fix d_c1, d_c2, d_c3, d_a, d_b, d_e, d_f, d_k, d_l, d_m, d_n, d_ox, d_oy;
    assign {d_c1, d_c2, d_c3, d_a, d_b, d_e, d_f, d_k, d_l, d_m, d_n, d_ox, d_oy}
        = r_dl[ND-2];

    // Stage 3: products with px, py.
    stum_pkg::t_fix r_s3_p1, r_s3_p2, r_s3_c3, r_s3_q1, r_s3_q2, r_s3_s1, r_s3_s2;
    stum_pkg::t_fix r_s3_k, r_s3_l, r_s3_m, r_s3_n;
    stum_pkg::t_fix r_s3_z1, r_s3_z2, r_s3_z3;
    logic r_s3_hz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_p1 <= stum_pkg::fmul(n_px, d_c1);
            r_s3_p2 <= stum_pkg::fmul(n_py, d_c2);
            r_s3_c3 <= d_c3;
            r_s3_q1 <= stum_pkg::fmul(n_px, d_a);
            r_s3_q2 <= stum_pkg::fmul(n_py, d_b);
            r_s3_s1 <= stum_pkg::fmul(n_px, d_e);
            r_s3_s2 <= stum_pkg::fmul(n_py, d_f);
            r_s3_k <= d_k; r_s3_l <= d_l; r_s3_m <= d_m; r_s3_n <= d_n;
            r_s3_z1 <= stum_pkg::fmul(d_ox, d_c1);
            r_s3_z2 <= stum_pkg::fmul(d_oy, d_c2);
            r_s3_z3 <= stum_pkg::fmul(r_ozd[ND-2], d_c3);
            r_s3_hz <= r_dz[ND-2];
        end
    end

    // Stage 4: saturating sums, evaluated left to right.
    stum_pkg::t_fix r_s4_d, r_s4_nu, r_s4_nv, r_s4_nz;
    logic r_s4_hz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_d  <= stum_pkg::fadd(stum_pkg::fadd(r_s3_p1, r_s3_p2), r_s3_c3);
            r_s4_nu <= stum_pkg::fadd(stum_pkg::fsub(stum_pkg::fadd(r_s3_q1, r_s3_q2),
                                                     r_s3_k), r_s3_m);
            r_s4_nv <= stum_pkg::fadd(stum_pkg::fsub(stum_pkg::fadd(r_s3_s1, r_s3_s2),
                                                     r_s3_l), r_s3_n);
            r_s4_nz <= stum_pkg::fadd(stum_pkg::fadd(r_s3_z1, r_s3_z2), r_s3_z3);
            r_s4_hz <= r_s3_hz;
        end
    end

    logic n_dg;
    logic signed [63:0] n_den, n_nden;
    assign n_dg   = r_s4_hz || (r_s4_d == 0);
    assign n_den  = n_dg ? 64'sd1 : 64'(r_s4_d);
    assign n_nden = n_dg ? 64'sd1 : 64'(stum_pkg::sat(-80'(r_s4_d)));

    stum_pkg::t_fix q_u, q_v, q_z;
    stum_div u_du (.i_clk, .i_en(en), .i_num(80'(r_s4_nu) <<< F), .i_den(n_den), .o_q(q_u));
    stum_div u_dv (.i_clk, .i_en(en), .i_num(80'(r_s4_nv) <<< F), .i_den(n_nden), .o_q(q_v));
    stum_div u_dz (.i_clk, .i_en(en), .i_num(80'(r_s4_nz) <<< F), .i_den(n_den), .o_q(q_z));

    // The flag starts beside the divider inputs, so it needs the full divider depth.
    logic r_dg [0:ND-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dg[0] <= n_dg;
            for (int i = 1; i < ND; i++) r_dg[i] <= r_dg[i-1];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_degenerate <= r_dg[ND-1];
            o_tex_u   <= r_dg[ND-1] ? '0 : q_u;
            o_tex_v   <= r_dg[ND-1] ? '0 : q_v;
            o_depth_z <= r_dg[ND-1] ? '0 : q_z;
        end
    end
endmodule

// ===== design/stum_checker.sv =====
`timescale 1ns / 1ps
module stum_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_degenerate,
    input logic signed [31:0] o_tex_u,
    input logic signed [31:0] o_tex_v,
    input logic signed [31:0] o_depth_z
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tex_u) && $stable(o_degenerate))
        else $error("result changed under stall");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_tex_u == 0 && o_tex_v == 0 && o_depth_z == 0)
        else $error("degenerate result not zero");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");
endmodule

bind screen_to_texture_uvz_mapper stum_checker u_chk (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready,
    .o_degenerate, .o_tex_u, .o_tex_v, .o_depth_z
);
